// ===== sv/assert_macros.svh =====
// Assertion macros shared by the payload notice parser RTL.
// Included by modules that check their own control logic; needs clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/pnp_pkg.sv =====
// Types, character codes and the keyword table of the payload notice parser.
// Used by pnp_core, payload_notice_parser and the testbench; depends on nothing.
`default_nettype none

package pnp_pkg;

  typedef enum logic [3:0] {
    PH_KEY_P    = 4'd0,
    PH_KEY_A1   = 4'd1,
    PH_KEY_Y    = 4'd2,
    PH_KEY_L    = 4'd3,
    PH_KEY_O    = 4'd4,
    PH_KEY_A2   = 4'd5,
    PH_KEY_D    = 4'd6,
    PH_COMMA    = 4'd7,
    PH_DIGITS   = 4'd8,
    PH_NEWLINE  = 4'd9,
    PH_PAYLOAD  = 4'd10
  } phase_t;

  typedef enum logic {
    KIND_DATA = 1'b0,
    KIND_DONE = 1'b1
  } kind_t;

  localparam logic [7:0] CHAR_COMMA   = 8'h2C;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CAPACITY_RST = 8'd255;

  // One result beat as produced by the core.
  typedef struct packed {
    logic        valid;
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [7:0]  byte_position;
    logic [15:0] announced_length;
  } result_t;

  // Expected letter of PAYLOAD for each keyword phase.
  function automatic logic [7:0] keyword_char(input phase_t p);
    logic [7:0] ch;
    ch = 8'h00;
    case (p)
      PH_KEY_P:  ch = 8'h50;
      PH_KEY_A1: ch = 8'h41;
      PH_KEY_Y:  ch = 8'h59;
      PH_KEY_L:  ch = 8'h4C;
      PH_KEY_O:  ch = 8'h4F;
      PH_KEY_A2: ch = 8'h41;
      PH_KEY_D:  ch = 8'h44;
      default:   ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

// ===== sv/pnp_core.sv =====
// Parser state machine of the payload notice parser: phase, length and count.
// Depends on pnp_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module pnp_core (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             step,
  input  wire logic [7:0]       rx_byte,
  input  wire logic [7:0]       capacity,
  output pnp_pkg::result_t      res
);
  import pnp_pkg::*;

  phase_t      phase, phase_next;
  logic [15:0] length_value, length_value_next;
  logic [7:0]  stored_count, stored_count_next;
  logic        room;
  logic        is_digit;

  assign room     = ({1'b0, stored_count} + 9'd1) < {1'b0, capacity};
  assign is_digit = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_KEY_P;
      length_value <= 16'd0;
      stored_count <= 8'd0;
    end else if (step) begin
      phase        <= phase_next;
      length_value <= length_value_next;
      stored_count <= stored_count_next;
    end
  end

  always_comb begin
    phase_next                = phase;
    length_value_next         = length_value;
    stored_count_next         = stored_count;
    res.valid                 = 1'b0;
    res.kind                  = KIND_DATA;
    res.data_byte             = 8'd0;
    res.byte_position         = stored_count;
    res.announced_length      = length_value;
    unique case (phase) inside
      PH_KEY_P, PH_KEY_A1, PH_KEY_Y, PH_KEY_L, PH_KEY_O, PH_KEY_A2, PH_KEY_D: begin
        // a wrong letter restarts without retrying the byte
        if (rx_byte == keyword_char(phase)) phase_next = phase_t'(4'(phase) + 4'd1);
        else phase_next = PH_KEY_P;
      end
      PH_COMMA: begin
        if (rx_byte == CHAR_COMMA) begin
          phase_next        = PH_DIGITS;
          length_value_next = 16'd0;
        end
      end
      PH_DIGITS: begin
        if (is_digit) begin
          length_value_next = (length_value << 3) + (length_value << 1)
                              + {12'd0, rx_byte[3:0]};
        end else begin
          phase_next        = PH_NEWLINE;
          stored_count_next = 8'd0;
        end
      end
      PH_NEWLINE: begin
        if (rx_byte == CHAR_NEWLINE) phase_next = PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        res.valid = 1'b1;
        if (room && ({8'd0, stored_count} < length_value)) begin
          res.data_byte     = rx_byte;
          stored_count_next = stored_count + 8'd1;
        end else begin
          // drop this byte, report completion and restart
          res.kind          = KIND_DONE;
          stored_count_next = 8'd0;
          phase_next        = PH_KEY_P;
        end
      end
      default: phase_next = PH_KEY_P;
    endcase
  end

  `ASSERT_NEXT(a_done_restart, step && res.valid && res.kind == KIND_DONE,
    phase == PH_KEY_P && stored_count == 8'd0, "completion did not restart parser")
  `ASSERT_IMPL(a_data_in_bounds, step && res.valid && res.kind == KIND_DATA,
    {8'd0, stored_count} < length_value && stored_count < capacity,
    "payload byte passed beyond length or capacity")
  `ASSERT_NEXT(a_count_advance, step && res.valid && res.kind == KIND_DATA,
    stored_count == $past(stored_count) + 8'd1, "stored count did not advance")
  `ASSERT_IMPL(a_result_phase, res.valid, phase == PH_PAYLOAD,
    "result outside payload phase")

endmodule

`default_nettype wire

// ===== sv/payload_notice_parser.sv =====
// Top level of the payload notice parser: input register, parser core, result register.
// Depends on pnp_pkg, pnp_core and assert_macros.svh.
//
//   channel | handshake             | payload
//   --------+-----------------------+---------------------------------------------------
//   input   | in_valid / in_ready   | rx_byte
//   result  | out_valid / out_ready | kind, data_byte, byte_position, announced_length
//   config  | cfg_valid / cfg_ready | cfg_data (buffer capacity)
//
// One byte is accepted per cycle while in_ready is high; its result, if any, is presented
// from the result register. The parser core computes the next phase, length and count
// combinationally between the input register and the result register.
// A stalled result register holds a full input register, which then holds in_ready low.
// Reset clears the phase, length and count and sets the capacity to 255; in_ready and
// cfg_ready stay low during reset, and cfg_ready is high otherwise.
`default_nettype none

`include "assert_macros.svh"

module payload_notice_parser (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    rx_byte,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic               kind,
  output logic [7:0]         data_byte,
  output logic [7:0]         byte_position,
  output logic [15:0]        announced_length,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [7:0]    cfg_data
);
  import pnp_pkg::*;

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic [7:0] capacity;
  logic       advance;
  logic       step;
  result_t    res;

  assign cfg_ready = !rst;
  assign advance   = !out_valid || out_ready;
  assign step      = s1_valid && advance;
  assign in_ready  = !rst && (!s1_valid || advance);

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RST;
    end else if (cfg_valid && cfg_ready) begin
      capacity <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (step) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) s1_byte <= rx_byte;
  end

  pnp_core u_core (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .rx_byte  (s1_byte),
    .capacity (capacity),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && res.valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // load the result beat only when the core produces one
  always_ff @(posedge clk) begin
    if (step && res.valid) begin
      kind             <= res.kind;
      data_byte        <= res.data_byte;
      byte_position    <= res.byte_position;
      announced_length <= res.announced_length;
    end
  end

  `ASSERT_IMPL(a_ready_when_empty, !s1_valid, in_ready,
    "input refused with empty input register")
  `ASSERT_NEXT(a_stall_holds_stage, s1_valid && out_valid && !out_ready,
    s1_valid && s1_byte == $past(s1_byte), "input register lost a byte under stall")
  `ASSERT_NEXT(a_done_has_no_data, step && res.valid && res.kind == KIND_DONE,
    out_valid && data_byte == 8'd0, "completion beat carries data")

endmodule

`default_nettype wire

// ===== sim/payload_notice_parser_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for payload_notice_parser: drives modem bytes and capacity
// writes, predicts every payload and completion beat, and checks the results. Depends on pnp_pkg.

module payload_notice_parser_tb;
  import pnp_pkg::*;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [7:0]  position;
    logic [15:0] length;
  } notice_beat_t;

  // P A Y L O A D
  localparam logic [7:0] NOTICE_WORD [0:6] = '{8'h50, 8'h41, 8'h59, 8'h4C, 8'h4F, 8'h41, 8'h44};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        kind;
  logic [7:0]  data_byte;
  logic [7:0]  byte_position;
  logic [15:0] announced_length;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = 8'h00;

  // parser state as predicted from the accepted bytes
  phase_t      ph = PH_KEY_P;
  logic [15:0] ann_len = 16'h0000;
  logic [7:0]  stored = 8'h00;
  logic [7:0]  capacity = CAPACITY_RST;

  notice_beat_t pending_beats[$];
  notice_beat_t oldest;
  bit gaps_on = 1'b1;
  int n_errors = 0;
  int n_bytes = 0;
  int n_data = 0;
  int n_done = 0;
  int n_cfg = 0;

  payload_notice_parser u_top (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .rx_byte          (rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .kind             (kind),
    .data_byte        (data_byte),
    .byte_position    (byte_position),
    .announced_length (announced_length),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", pending_beats.size());
    $display("end of test: mismatches");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    if (n_errors < 100) $display("MISMATCH @%0t: %s", $time, msg);
    n_errors++;
  endtask

  task automatic predict_byte(input logic [7:0] b);
    notice_beat_t beat;
    case (ph)
      PH_COMMA: begin
        if (b == CHAR_COMMA) begin
          ph = PH_DIGITS;
          ann_len = 16'h0000;
        end
      end
      PH_DIGITS: begin
        if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
          ann_len = ann_len * 16'd10 + {8'h00, b - CHAR_ZERO};
        end else begin
          ph = PH_NEWLINE;
          stored = 8'h00;
        end
      end
      PH_NEWLINE: begin
        if (b == CHAR_NEWLINE) ph = PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        if (int'(stored) < int'(capacity) - 1 && int'(stored) < int'(ann_len)) begin
          beat = '{kind: KIND_DATA, data_byte: b, position: stored, length: ann_len};
          stored = stored + 8'd1;
        end else begin
          beat = '{kind: KIND_DONE, data_byte: 8'h00, position: stored, length: ann_len};
          stored = 8'h00;
          ph = PH_KEY_P;
        end
        pending_beats.push_back(beat);
      end
      default: begin
        // a wrong letter restarts the match without retrying this byte
        if (ph <= PH_KEY_D && b == NOTICE_WORD[int'(ph)]) ph = phase_t'(ph + 4'd1);
        else ph = PH_KEY_P;
      end
    endcase
  endtask

  // Hold valid until the beat is taken; leave it high for a back-to-back beat.
  task automatic send_byte(input logic [7:0] b);
    while (gaps_on && $urandom_range(0, 99) < 27) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    n_bytes++;
    predict_byte(b);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic logic [7:0] byte_other_than(input logic [7:0] avoid);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == avoid);
    return b;
  endfunction

  function automatic logic [7:0] non_digit_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b >= CHAR_ZERO && b <= CHAR_NINE);
    return b;
  endfunction

  // Drop valid and wait until every predicted result is out and the pipe is empty.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    capacity = value;
    n_cfg++;
  endtask

  // One notice with random content; a few are cut short or mangled.
  task automatic send_random_notice();
    int mode;
    int pick;
    string digits;
    repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 255)));
    mode = $urandom_range(0, 99);
    if (mode < 8) begin
      pick = $urandom_range(1, 6);
      for (int i = 0; i < pick; i++) send_byte(NOTICE_WORD[i]);
      send_byte(8'($urandom_range(0, 255)));
      return;
    end
    send_text("PAYLOAD");
    repeat ($urandom_range(0, 2)) send_byte(byte_other_than(CHAR_COMMA));
    send_byte(CHAR_COMMA);
    pick = $urandom_range(0, 99);
    if (pick < 10) digits = "";
    else if (pick < 15) digits = $sformatf("%0d", $urandom_range(65536, 9999999));
    else if (pick < 25) digits = $sformatf("00%0d", $urandom_range(0, 9));
    else digits = $sformatf("%0d", $urandom_range(0, 12));
    send_text(digits);
    send_byte(non_digit_byte());
    if (mode < 14) begin
      // no newline yet: leave the parser waiting for one
      repeat ($urandom_range(1, 4)) send_byte(byte_other_than(CHAR_NEWLINE));
      return;
    end
    repeat ($urandom_range(0, 2)) send_byte(byte_other_than(CHAR_NEWLINE));
    send_byte(CHAR_NEWLINE);
    while (ph == PH_PAYLOAD) send_byte(8'($urandom_range(0, 255)));
  endtask

  // Length wraps modulo 65536, the capacity cuts the payload, bytes 00 and FF pass,
  // and a broken keyword prefix is not retried.
  task automatic test_overflow_and_capacity();
    set_capacity(8'd3);
    send_text("PAP");
    send_text("PAYLOAD,70000\n");
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h7E);
    wait_idle();
  endtask

  // No digits gives length zero; capacity zero completes on the first payload byte.
  task automatic test_empty_length_zero_capacity();
    set_capacity(8'd0);
    send_text("PAYLOAD,x\n");
    send_byte(8'hA5);
    wait_idle();
  endtask

  task automatic test_random_traffic(input logic [7:0] cap, input int count, input bit gaps);
    int start;
    set_capacity(cap);
    gaps_on = gaps;
    start = n_bytes;
    while (n_bytes - start < count) send_random_notice();
    wait_idle();
  endtask

  // Check each result beat against the oldest prediction; stall the output at random.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_beats.size() == 0) begin
        report_mismatch("result beat with nothing pending");
      end else begin
        oldest = pending_beats.pop_front();
        if (kind !== oldest.kind)
          report_mismatch($sformatf("kind %0d, want %0d", kind, oldest.kind));
        if (data_byte !== oldest.data_byte)
          report_mismatch($sformatf("data_byte %h, want %h", data_byte, oldest.data_byte));
        if (byte_position !== oldest.position)
          report_mismatch($sformatf("byte_position %0d, want %0d",
                                    byte_position, oldest.position));
        if (announced_length !== oldest.length)
          report_mismatch($sformatf("announced_length %0d, want %0d",
                                    announced_length, oldest.length));
        if (oldest.kind == KIND_DONE) n_done++;
        else n_data++;
      end
    end
    out_ready <= !gaps_on || ($urandom_range(0, 99) >= 27);
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_overflow_and_capacity();
    test_empty_length_zero_capacity();
    test_random_traffic(8'd255, 400, 1'b1);
    test_random_traffic(8'd1, 150, 1'b1);
    test_random_traffic(8'd0, 150, 1'b1);
    test_random_traffic(8'd2, 150, 1'b0);
    test_random_traffic(8'($urandom_range(3, 255)), 400, 1'b1);
    test_random_traffic(8'($urandom_range(3, 20)), 450, 1'b1);
    $display("covered %0d bytes over %0d capacity settings", n_bytes, n_cfg);
    $display("checked %0d payload beats and %0d completions", n_data, n_done);
    if (n_errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/pnp_pkg.sv
sv/pnp_core.sv
sv/payload_notice_parser.sv
sim/payload_notice_parser_tb.sv
